// ===== rtl/ffba_pkg.sv =====
`default_nettype none
package ffba_pkg;

	// table size used when the top level is not overridden
	localparam int NUM_BLOCKS_DEF = 16;

	// field widths of the stream beats
	localparam int KIND_W = 1;
	localparam int BLK_W  = 4;
	localparam int AMT_W  = 16;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 8;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_LOAD    = 1'b0;
	localparam logic [KIND_W-1:0] KIND_REQUEST = 1'b1;

	// configuration port
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 5;
	localparam logic [CFG_ADDR_W-1:0] REG_SHARE_MODE    = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_BLOCKS_IN_USE = 1'd1;
	localparam logic [CFG_DATA_W-1:0] BLOCKS_IN_USE_RST = 5'd16;

	// verdict of the shared fit unit for one table entry
	typedef struct packed {
		logic             hit;
		logic [AMT_W-1:0] new_cap;
	} fit_res_t;

endpackage
`default_nettype wire

// ===== rtl/ffba_cap_ram.sv =====
`default_nettype none
module ffba_cap_ram #(
	parameter int DEPTH = ffba_pkg::NUM_BLOCKS_DEF,
	parameter int IDX_W = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       we,
	input  wire logic [IDX_W-1:0]           waddr,
	input  wire logic [ffba_pkg::AMT_W-1:0] wdata,
	input  wire logic [IDX_W-1:0]           raddr,
	output      logic [ffba_pkg::AMT_W-1:0] rdata
);
	import ffba_pkg::*;

	logic [AMT_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [AMT_W-1:0] rdata_q;

	// never-loaded entries read as zero capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= vld_q[raddr] ? mem[raddr] : '0;
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/ffba_fit_unit.sv =====
`default_nettype none
module ffba_fit_unit (
	input  wire logic                       share,
	input  wire logic                       occ,
	input  wire logic [ffba_pkg::AMT_W-1:0] cap,
	input  wire logic [ffba_pkg::AMT_W-1:0] amount,
	output      ffba_pkg::fit_res_t         res
);
	import ffba_pkg::*;

	// one compare and one subtract, reused for every entry of the scan
	always_comb begin
		res.hit     = (cap >= amount) && (share || !occ);
		res.new_cap = cap - amount;
	end

endmodule
`default_nettype wire

// ===== rtl/first_fit_block_allocator.sv =====
`default_nettype none
// first-fit block allocator
//
// input stream s_*: one beat per item; s_tuser is the item kind (load or request),
// s_tdata holds block_number and amount. a load writes one table entry's capacity
// and clears its occupied mark; it gives no output beat.
// a request walks the table from entry 0 up to min(blocks_in_use, NUM_BLOCKS)-1
// through one shared compare/subtract unit, one entry per cycle, with the
// capacity memory read in the cycle before the compare. the walk stops at the
// first hit; a miss walks the whole searched range, and with no entry to search
// the request goes straight to its result. s_tready is low while a request is in
// flight, so the block takes no new item until the result is in the output register.
// output stream m_*: m_tuser is found, m_tdata holds chosen_block.
// if the receiver stalls, the result waits in the output register and a finished
// scan holds until that register is free. configuration (share_mode, blocks_in_use)
// is written through cfg_we/cfg_addr/cfg_wdata; the user must write it only while
// the block is idle, as the block itself does not enforce this.
// reset: capacities read as zero, all occupied marks clear, share_mode 0,
// blocks_in_use 16, no output beat pending.
module first_fit_block_allocator #(
	parameter int NUM_BLOCKS = ffba_pkg::NUM_BLOCKS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration write port
	input  wire logic                            cfg_we,
	input  wire logic [ffba_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [ffba_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// input items
	input  wire logic                            s_tvalid,
	output      logic                            s_tready,
	input  wire logic [ffba_pkg::IN_DATA_W-1:0]  s_tdata,  // block_number[3:0], amount[19:4]
	input  wire logic [ffba_pkg::KIND_W-1:0]     s_tuser,  // kind[0]
	// results
	output      logic                            m_tvalid,
	input  wire logic                            m_tready,
	output      logic [ffba_pkg::OUT_DATA_W-1:0] m_tdata,  // chosen_block[3:0]
	output      logic                            m_tuser   // found[0]
);
	import ffba_pkg::*;

	localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]            state_q;
	logic                  share_q;
	logic [CFG_DATA_W-1:0] biu_q;
	logic [NUM_BLOCKS-1:0] occ_q;

	logic [AMT_W-1:0] amt_q;
	logic [CNT_W-1:0] limit_q;
	logic [CNT_W-1:0] rd_cnt_q;
	logic             pend_s1;   // memory data for idx_s1 is on rd_cap
	logic [IDX_W-1:0] idx_s1;
	logic             res_found_q;
	logic [BLK_W-1:0] res_idx_q;
	logic             m_valid_q;
	logic             m_found_q;
	logic [BLK_W-1:0] m_idx_q;

	logic [BLK_W-1:0] in_blk;
	logic [AMT_W-1:0] in_amt;
	logic             in_acc;
	logic             in_range;
	logic             load_we;
	logic [CNT_W-1:0] lim;
	logic             issue;
	logic             last;
	logic             out_free;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [AMT_W-1:0] ram_wdata;
	logic [AMT_W-1:0] rd_cap;
	fit_res_t         fit;

	assign in_blk   = s_tdata[BLK_W-1:0];
	assign in_amt   = s_tdata[BLK_W +: AMT_W];
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign in_range = (32'(in_blk) < NUM_BLOCKS);
	assign load_we  = in_acc && (s_tuser == KIND_LOAD) && in_range;

	// searched entries: blocks_in_use clipped to the table size
	assign lim = (32'(biu_q) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS) : CNT_W'(biu_q);

	assign issue    = (state_q == ST_SCAN) && (rd_cnt_q < limit_q);
	assign last     = (CNT_W'(idx_s1) + CNT_W'(1)) == limit_q;
	assign out_free = !m_valid_q || m_tready;

	// capacity write: load in idle, write-back of a shared-mode hit in scan
	always_comb begin
		if (state_q == ST_SCAN) begin
			ram_we    = pend_s1 && fit.hit && share_q;
			ram_waddr = idx_s1;
			ram_wdata = fit.new_cap;
		end else begin
			ram_we    = load_we;
			ram_waddr = IDX_W'(in_blk);
			ram_wdata = in_amt;
		end
	end

	ffba_cap_ram #(
		.DEPTH(NUM_BLOCKS),
		.IDX_W(IDX_W)
	) u_cap_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_cnt_q[IDX_W-1:0]),
		.rdata (rd_cap)
	);

	ffba_fit_unit u_fit (
		.share (share_q),
		.occ   (occ_q[idx_s1]),
		.cap   (rd_cap),
		.amount(amt_q),
		.res   (fit)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			share_q <= 1'b0;
			biu_q   <= BLOCKS_IN_USE_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_SHARE_MODE:    share_q <= cfg_wdata[0];
				REG_BLOCKS_IN_USE: biu_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// occupied marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (load_we) begin
			occ_q[IDX_W'(in_blk)] <= 1'b0;
		end else if ((state_q == ST_SCAN) && pend_s1 && fit.hit && !share_q) begin
			occ_q[idx_s1] <= 1'b1;
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_cnt_q  <= '0;
			pend_s1   <= 1'b0;
			limit_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			// output register: load a finished result, else drop an accepted beat
			if ((state_q == ST_FIN) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (s_tuser == KIND_REQUEST)) begin
						rd_cnt_q <= '0;
						pend_s1  <= 1'b0;
						limit_q  <= lim;
						state_q  <= (lim == '0) ? ST_FIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + CNT_W'(1);
					end
					if (pend_s1 && (fit.hit || last)) begin
						pend_s1 <= 1'b0;
						state_q <= ST_FIN;
					end else begin
						pend_s1 <= issue;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			amt_q <= in_amt;
		end
		if (issue) begin
			idx_s1 <= rd_cnt_q[IDX_W-1:0];
		end
		if ((state_q == ST_IDLE) && in_acc) begin
			res_found_q <= 1'b0;
			res_idx_q   <= '0;
		end else if ((state_q == ST_SCAN) && pend_s1 && fit.hit) begin
			res_found_q <= 1'b1;
			res_idx_q   <= BLK_W'(idx_s1);
		end
		if ((state_q == ST_FIN) && out_free) begin
			m_found_q <= res_found_q;
			m_idx_q   <= res_idx_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_found_q;
	assign m_tdata  = {{(OUT_DATA_W - BLK_W){1'b0}}, m_idx_q};

	// a miss always reports block zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("miss result carries a nonzero block index");

	// reads never run past the searched range
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_cnt_q <= limit_q)
		else $error("scan counter beyond limit");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (CNT_W'(idx_s1) < limit_q))
		else $error("compared entry outside searched range");

	// a whole-block hit leaves its entry marked occupied
	a_occ_set: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCAN) && pend_s1 && fit.hit && !share_q)
		|=> occ_q[$past(idx_s1)])
		else $error("whole-block hit did not mark entry occupied");

	// input is held off during a scan
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !s_tready)
		else $error("input accepted during scan");

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none
module tb_top;
	import ffba_pkg::*;

	localparam int NB          = NUM_BLOCKS_DEF;
	localparam int SCAN_LAT    = 24;    // wait for a miss over a full table, plus margin
	localparam int STALL_LIMIT = 4000;  // cycles without any beat before giving up
	localparam int HOLD_CYCLES = 400;   // long receiver hold-off to back up the block
	localparam int NUM_PHASES  = 9;
	localparam int PHASE_ITEMS = 205;

	// one allocation outcome as seen on the output stream
	typedef struct packed {
		logic             found;
		logic [BLK_W-1:0] blk;
	} alloc_t;

	// directed script: either a register write or a stream item
	typedef enum logic {ROW_REG, ROW_ITEM} row_kind_t;
	typedef struct packed {
		row_kind_t              rk;
		logic [CFG_ADDR_W-1:0]  addr;
		logic [CFG_DATA_W-1:0]  val;
		logic [KIND_W-1:0]      kind;
		logic [BLK_W-1:0]       blk;
		logic [AMT_W-1:0]       amt;
		logic                   pinned;   // expected outcome typed in below
		alloc_t                 known;
	} script_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;   // block_number[3:0], amount[19:4]
	logic [KIND_W-1:0]     s_tuser;   // kind[0]
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // chosen_block[3:0]
	logic                  m_tuser;   // found[0]

	first_fit_block_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the allocator table and its registers
	logic [AMT_W-1:0]      cap_model [NB];
	logic                  busy_model [NB];
	logic                  share_model;
	logic [CFG_DATA_W-1:0] span_model;

	alloc_t pending_allocs [$];   // outcomes still owed by the block
	int     n_fail = 0;
	int     quiet_cycles = 0;

	// knobs shared between the stimulus, the receiver and the monitor
	int     send_idle_pct = 0;
	int     recv_idle_pct = 0;
	bit     hold_req = 1'b0;
	bit     pin_on = 1'b0;
	alloc_t pin_val = '0;

	// first-fit search over the shadow table; updates it like the block does
	function automatic alloc_t predict_alloc(logic [AMT_W-1:0] size);
		int     lim;
		alloc_t r;
		lim = (span_model > NB) ? NB : int'(span_model);
		r = '0;
		for (int j = 0; j < lim; j++) begin
			// whole-block mode also needs the entry to be free
			if (cap_model[j] >= size && (share_model || !busy_model[j])) begin
				if (share_model)
					cap_model[j] = cap_model[j] - size;
				else
					busy_model[j] = 1'b1;
				r.found = 1'b1;
				r.blk   = BLK_W'(j);
				break;
			end
		end
		return r;
	endfunction

	// monitor: model update on every input beat, compare on every output beat
	always @(posedge clk or negedge arst_n) begin
		alloc_t got;
		alloc_t want;
		alloc_t calc;
		if (!arst_n) begin
			for (int j = 0; j < NB; j++) begin
				cap_model[j]  = '0;
				busy_model[j] = 1'b0;
			end
			share_model  = 1'b0;
			span_model   = BLOCKS_IN_USE_RST;
			quiet_cycles = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_SHARE_MODE:    share_model = cfg_wdata[0];
					REG_BLOCKS_IN_USE: span_model  = cfg_wdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == KIND_LOAD) begin
					// loads rewrite capacity and free the entry, no output beat
					cap_model[s_tdata[BLK_W-1:0]]  = s_tdata[BLK_W +: AMT_W];
					busy_model[s_tdata[BLK_W-1:0]] = 1'b0;
				end else begin
					calc = predict_alloc(s_tdata[BLK_W +: AMT_W]);
					pending_allocs.push_back(pin_on ? pin_val : calc);
				end
			end
			if (m_tvalid && m_tready) begin
				got.found = m_tuser;
				got.blk   = m_tdata[BLK_W-1:0];
				if (pending_allocs.size() == 0) begin
					n_fail++;
					$display("%0t unexpected result beat: found=%0b block=%0d", $time,
						got.found, got.blk);
				end else begin
					want = pending_allocs.pop_front();
					if (got.found !== want.found) begin
						n_fail++;
						$display("%0t found mismatch: expected %0b, actual %0b", $time,
							want.found, got.found);
					end
					if (m_tdata !== OUT_DATA_W'(want.blk)) begin
						n_fail++;
						$display("%0t chosen_block mismatch: expected %0d, actual %0d",
							$time, want.blk, m_tdata);
					end
				end
			end
			// watchdog on beats of either stream
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t no beat for %0d cycles", $time, STALL_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// receiver: random back-pressure, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// one input beat; leaves s_tvalid high so back-to-back beats need no toggle
	task automatic offer_item(logic [KIND_W-1:0] kind, logic [BLK_W-1:0] blk,
		logic [AMT_W-1:0] amt, logic pinned, alloc_t known);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		pin_on  = pinned;
		pin_val = known;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {{(IN_DATA_W - BLK_W - AMT_W){1'b0}}, amt, blk};
		do
			@(posedge clk);
		while (!(s_tvalid && s_tready));
		@(negedge clk);
		pin_on = 1'b0;
	endtask

	// drain everything and let a trailing scan finish before touching registers
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_allocs.size() != 0)
			@(negedge clk);
		repeat (SCAN_LAT) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	// script row builders
	function automatic script_row_t reg_row(logic [CFG_ADDR_W-1:0] addr,
		logic [CFG_DATA_W-1:0] val);
		script_row_t r;
		r      = '0;
		r.rk   = ROW_REG;
		r.addr = addr;
		r.val  = val;
		return r;
	endfunction

	function automatic script_row_t load_row(logic [BLK_W-1:0] blk, logic [AMT_W-1:0] amt);
		script_row_t r;
		r      = '0;
		r.rk   = ROW_ITEM;
		r.kind = KIND_LOAD;
		r.blk  = blk;
		r.amt  = amt;
		return r;
	endfunction

	// request; when pinned, found/blk are the typed-in expectation
	function automatic script_row_t req_row(logic [AMT_W-1:0] amt, logic pinned,
		logic found, logic [BLK_W-1:0] blk);
		script_row_t r;
		r             = '0;
		r.rk          = ROW_ITEM;
		r.kind        = KIND_REQUEST;
		r.blk         = BLK_W'($urandom);   // ignored by the block
		r.amt         = amt;
		r.pinned      = pinned;
		r.known.found = found;
		r.known.blk   = blk;
		return r;
	endfunction

	initial begin : stim_seq
		script_row_t      script [$];
		script_row_t      r;
		logic [BLK_W-1:0] blk;
		logic [AMT_W-1:0] amt;
		logic [CFG_DATA_W-1:0] span;
		int               sel;
		int               pick;

		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_addr  = '0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part, starting from the reset table (all empty, all free)
		script.push_back(req_row(16'h0000, 1, 1, 0));   // zero size fits an empty entry
		script.push_back(req_row(16'h0001, 1, 0, 0));   // every capacity is zero: miss
		script.push_back(load_row(0, 16'hFFFF));
		script.push_back(load_row(15, 16'd100));
		script.push_back(load_row(7, 16'h0000));
		script.push_back(req_row(16'hFFFF, 1, 1, 0));   // reload freed entry 0
		script.push_back(req_row(16'hFFFF, 1, 0, 0));   // entry 0 now taken
		script.push_back(req_row(16'd100, 1, 1, 15));   // only the top entry is big enough and free
		script.push_back(req_row(16'h0000, 0, 0, 0));
		script.push_back(reg_row(REG_BLOCKS_IN_USE, 5'd0));
		script.push_back(req_row(16'h0000, 1, 0, 0));   // nothing searched
		script.push_back(reg_row(REG_BLOCKS_IN_USE, 5'd31));  // clamps to the table size
		script.push_back(req_row(16'h0000, 0, 0, 0));
		script.push_back(reg_row(REG_SHARE_MODE, 5'd1));
		script.push_back(load_row(3, 16'd50));
		script.push_back(req_row(16'd20, 0, 0, 0));
		script.push_back(req_row(16'h0000, 1, 1, 0));   // shared: first entry, subtracts 0
		script.push_back(reg_row(REG_BLOCKS_IN_USE, 5'd1));
		script.push_back(req_row(16'hFFFF, 1, 0, 0));   // entry 0 was reduced
		script.push_back(reg_row(REG_BLOCKS_IN_USE, 5'd16));
		script.push_back(reg_row(REG_SHARE_MODE, 5'd0));
		script.push_back(req_row(16'hFFEB, 0, 0, 0));   // whole mode sees reduced capacity
		script.push_back(load_row(5, 16'h8000));
		script.push_back(load_row(10, 16'h7FFF));
		script.push_back(req_row(16'h7FFF, 0, 0, 0));
		script.push_back(req_row(16'h8000, 0, 0, 0));
		script.push_back(req_row(16'd30, 0, 0, 0));

		send_idle_pct = 28;
		recv_idle_pct = 81;
		foreach (script[i]) begin
			r = script[i];
			if (r.rk == ROW_REG) begin
				settle();
				write_reg(r.addr, r.val);
			end else begin
				offer_item(r.kind, r.blk, r.amt, r.pinned, r.known);
			end
		end

		// random phases: each one a register setting and an idling pattern
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: span = 5'd16;
				1: span = 5'd0;
				2: span = 5'd31;
				3: span = 5'd1;
				4: span = CFG_DATA_W'($urandom_range(2, 15));
				5: span = 5'd16;
				6: span = CFG_DATA_W'($urandom_range(17, 30));
				7: span = 5'd16;
				default: span = CFG_DATA_W'($urandom_range(0, 31));
			endcase
			settle();
			write_reg(REG_SHARE_MODE, CFG_DATA_W'(p % 2));
			write_reg(REG_BLOCKS_IN_USE, span);
			case (p / 3)
				0: begin
					send_idle_pct = 28;
					recv_idle_pct = 81;
				end
				1: begin
					send_idle_pct = 81;
					recv_idle_pct = 28;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			// stall the output for a while and keep offering beats
			if (p == 2 || p == 7)
				hold_req = 1'b1;

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				blk = BLK_W'($urandom);
				sel = $urandom_range(0, 99);
				if (sel < 40) begin
					// load: mix of full range, small, and the extremes
					case ($urandom_range(0, 7))
						0:       amt = '0;
						1:       amt = '1;
						2, 3:    amt = AMT_W'($urandom_range(0, 255));
						default: amt = AMT_W'($urandom);
					endcase
					offer_item(KIND_LOAD, blk, amt, 1'b0, '0);
				end else begin
					// request: mostly sized against a known capacity so it can fit
					case ($urandom_range(0, 19))
						0:       amt = '0;
						1:       amt = '1;
						2, 3:    amt = AMT_W'($urandom);
						default: begin
							pick = $urandom_range(0, NB - 1);
							amt  = AMT_W'($urandom_range(0, cap_model[pick]));
						end
					endcase
					offer_item(KIND_REQUEST, blk, amt, 1'b0, '0);
				end
			end
		end

		// drain, then give a stray beat time to show up
		s_tvalid <= 1'b0;
		while (pending_allocs.size() != 0)
			@(negedge clk);
		repeat (SCAN_LAT) @(negedge clk);
		if (n_fail == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire
